// ===== rtl/drs_pkg.sv =====
// Shared definitions for the digit run extractor and sorter.
// Holds character constants, the controller state type and the command and
// status structs that join the controller to the datapath. No dependencies.
package drs_pkg;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam int         DIGIT_BITS   = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ_A,
      ST_LOAD_A,
      ST_STEP,
      ST_CMP
   } ctl_state_type;

   typedef struct packed {
      logic clear_line;
      logic init_a;
      logic inc_a;
      logic set_b;
      logic rd_en;
      logic rd_sel_b;
      logic latch_cur;
      logic cmp;
      logic emit;
      logic emit_none;
   } ctl_cmd_type;

   typedef struct packed {
      logic line_end;
      logic count_zero;
      logic b_lt_count;
      logic a_is_last;
   } ctl_status_type;

endpackage

// ===== rtl/drs_ctrl.sv =====
// Controller state machine for the digit run extractor and sorter.
// Sequences the end-of-line sort passes and result transfers; uses drs_pkg.
module drs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  drs_pkg::ctl_status_type status,
   output drs_pkg::ctl_cmd_type    cmd,
   output logic                    busy
);
   import drs_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.line_end) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.count_zero) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ_A;
            end
         end
         ST_READ_A: begin
            state_in = ST_LOAD_A;
         end
         ST_LOAD_A: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (status.b_lt_count) begin
               state_in = ST_CMP;
            end else if (status.a_is_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ_A;
            end
         end
         ST_CMP: begin
            state_in = ST_STEP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
         end
         ST_CHECK: begin
            if (status.count_zero) begin
               cmd.emit_none  = 1'b1;
               cmd.clear_line = 1'b1;
            end else begin
               cmd.init_a = 1'b1;
            end
         end
         ST_READ_A: begin
            cmd.rd_en = 1'b1;
            cmd.set_b = 1'b1;
         end
         ST_LOAD_A: begin
            cmd.latch_cur = 1'b1;
         end
         ST_STEP: begin
            if (status.b_lt_count) begin
               cmd.rd_en    = 1'b1;
               cmd.rd_sel_b = 1'b1;
            end else begin
               cmd.emit = 1'b1;
               if (status.a_is_last) begin
                  cmd.clear_line = 1'b1;
               end else begin
                  cmd.inc_a = 1'b1;
               end
            end
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/drs_datapath.sv =====
// Datapath of the digit run extractor and sorter: digit accumulator,
// number store memory, sort pointers and result registers; uses drs_pkg.
module drs_datapath #(
   parameter int MAX_NUMBERS = 64,
   parameter int VALUE_BITS  = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              req_character,
   input  logic                    req_end_of_line,
   input  drs_pkg::ctl_cmd_type    cmd,
   output drs_pkg::ctl_status_type status,
   output logic                    rsp_valid,
   output logic [VALUE_BITS-1:0]   rsp_value,
   output logic                    rsp_last,
   output logic                    rsp_none_found,
   output logic                    rsp_overflow
);
   import drs_pkg::*;

   localparam int CNT_W  = $clog2(MAX_NUMBERS + 1);
   localparam int ADDR_W = (MAX_NUMBERS > 1) ? $clog2(MAX_NUMBERS) : 1;
   localparam int EXT_W  = VALUE_BITS + 4;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   logic [VALUE_BITS-1:0] store_mem [MAX_NUMBERS];

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  in_number_ff, in_number_in;
   logic                  ovf_ff, ovf_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     a_ff, a_in;
   logic [CNT_W-1:0]      b_ff, b_in;
   logic [VALUE_BITS-1:0] cur_ff, cur_in;
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_none_ff, rsp_none_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  is_digit;
   logic                  line_end;
   logic [DIGIT_BITS-1:0] digit;
   logic [EXT_W-1:0]      acc_ext;
   logic [EXT_W-1:0]      prod;
   logic                  saturate;
   logic                  add_digit;
   logic                  close_run;
   logic                  store_ok;
   logic                  close_wr;
   logic                  swap_wr;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [ADDR_W-1:0]     rd_addr;

   assign is_digit  = req_character inside {[CHAR_ZERO:CHAR_NINE]};
   assign line_end  = req_end_of_line || (req_character == CHAR_NEWLINE);
   assign digit     = DIGIT_BITS'(req_character - CHAR_ZERO);
   assign acc_ext   = EXT_W'(acc_ff);
   assign prod      = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(digit);
   assign saturate  = prod > EXT_W'(VALUE_MAX);
   assign add_digit = accept && !line_end && is_digit;
   assign close_run = accept && (line_end || !is_digit);
   assign store_ok  = count_ff < CNT_W'(MAX_NUMBERS);
   assign close_wr  = close_run && in_number_ff && store_ok;
   assign swap_wr   = cmd.cmp && (cur_ff > rd_data_ff);
   assign wr_en     = close_wr || swap_wr;
   assign wr_addr   = swap_wr ? b_ff[ADDR_W-1:0] : count_ff[ADDR_W-1:0];
   assign wr_data   = swap_wr ? cur_ff : acc_ff;
   assign rd_addr   = cmd.rd_sel_b ? b_ff[ADDR_W-1:0] : a_ff;

   assign status.line_end   = line_end;
   assign status.count_zero = (count_ff == '0);
   assign status.b_lt_count = (b_ff < count_ff);
   assign status.a_is_last  = ((CNT_W'(a_ff) + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      in_number_in = in_number_ff;
      ovf_in       = ovf_ff;
      count_in     = count_ff;
      if (add_digit) begin
         in_number_in = 1'b1;
         if (saturate) begin
            acc_in = VALUE_MAX;
            ovf_in = 1'b1;
         end else begin
            acc_in = prod[VALUE_BITS-1:0];
         end
      end
      if (close_run) begin
         in_number_in = 1'b0;
         acc_in       = '0;
         if (in_number_ff) begin
            if (store_ok) begin
               count_in = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
      if (cmd.clear_line) begin
         count_in     = '0;
         acc_in       = '0;
         in_number_in = 1'b0;
         ovf_in       = 1'b0;
      end
   end

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      cur_in = cur_ff;
      if (cmd.init_a) begin
         a_in = '0;
      end else if (cmd.inc_a) begin
         a_in = a_ff + ADDR_W'(1);
      end
      if (cmd.set_b) begin
         b_in = CNT_W'(a_ff) + CNT_W'(1);
      end else if (cmd.cmp) begin
         b_in = b_ff + CNT_W'(1);
      end
      if (cmd.latch_cur || swap_wr) begin
         cur_in = rd_data_ff;
      end
   end

   always_comb begin
      rsp_valid_in = cmd.emit || cmd.emit_none;
      rsp_value_in = cmd.emit_none ? '0 : cur_ff;
      rsp_last_in  = cmd.emit_none || status.a_is_last;
      rsp_none_in  = cmd.emit_none;
      rsp_ovf_in   = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         in_number_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         in_number_ff <= in_number_in;
         ovf_ff       <= ovf_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      cur_ff <= cur_in;
      if (rsp_valid_in) begin
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_none_ff  <= rsp_none_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_none_found = rsp_none_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

// ===== rtl/digit_run_extract_and_sort.sv =====
// Top level of the digit run extractor and sorter.
// Joins drs_ctrl and drs_datapath; uses drs_pkg for the command and status structs.

// Characters are taken one per clock while busy is low, and a digit run or a
// closed number never raises busy. An end of line (end_of_line set, or a
// newline character) raises busy while the stored numbers are sorted through
// the single read port of the number store, and also on a line without
// numbers. The sorted values leave one at a time, the smallest first, each
// held on the rsp_ ports for one cycle while rsp_valid is high; every transfer
// completes at that edge, so the receiver must take each one as it comes.
module digit_run_extract_and_sort #(
   parameter int MAX_NUMBERS = 64,
   parameter int VALUE_BITS  = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [7:0]            req_character,
   input  logic                  req_end_of_line,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_value,
   output logic                  rsp_last,
   output logic                  rsp_none_found,
   output logic                  rsp_overflow
);
   import drs_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           accept;

   assign accept = start && !busy;

   drs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   drs_datapath #(
      .MAX_NUMBERS (MAX_NUMBERS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_character   (req_character),
      .req_end_of_line (req_end_of_line),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last),
      .rsp_none_found  (rsp_none_found),
      .rsp_overflow    (rsp_overflow)
   );

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy)
      else $error("Controller is not idle after reset.");

   a_eol_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && status.line_end) |=> busy)
      else $error("End of line did not start the sort.");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none_found) |-> rsp_last)
      else $error("Empty line result is not marked last.");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("Controller still busy after the final transfer.");

endmodule

// ===== tb/drs_checker.sv =====
`timescale 1ns / 100ps
// Checker for digit_run_extract_and_sort: watches the character and result channels,
// predicts the sorted numbers of each line and compares every result transfer.
// Depends on drs_pkg for the character codes.
module drs_checker #(
   parameter int MAX_NUMBERS = 64,
   parameter int VALUE_BITS  = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [7:0]            req_character,
   input  logic                  req_end_of_line,
   input  logic                  rsp_valid,
   input  logic [VALUE_BITS-1:0] rsp_value,
   input  logic                  rsp_last,
   input  logic                  rsp_none_found,
   input  logic                  rsp_overflow,
   output int                    fail_count,
   output int                    pending_count,
   output int                    compared_count
);

   import drs_pkg::*;

   localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
      logic                  none_found;
      logic                  overflow;
   } number_result_type;

   number_result_type sorted_numbers_q[$];
   logic [63:0]    line_numbers[MAX_NUMBERS];
   int             line_count    = 0;
   logic [63:0]    run_value     = '0;
   bit             run_open      = 1'b0;
   bit             line_overflow = 1'b0;
   int             errors        = 0;
   int             compared      = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t ns: result %0d: %s", $time, compared, msg);
   endtask

   task automatic close_run();
      if (run_open) begin
         if (line_count < MAX_NUMBERS) begin
            line_numbers[line_count] = run_value & VALUE_MAX;
            line_count++;
         end else begin
            line_overflow = 1'b1;
         end
      end
      run_open  = 1'b0;
      run_value = '0;
   endtask

   task automatic take_character(input logic [7:0] ch, input logic eol);
      logic [63:0]       digit;
      logic [63:0]       swap;
      number_result_type res;
      if (eol || ch == CHAR_NEWLINE) begin
         close_run();
         for (int a = 0; a < line_count; a++) begin
            for (int b = a + 1; b < line_count; b++) begin
               if (line_numbers[a] > line_numbers[b]) begin
                  swap            = line_numbers[a];
                  line_numbers[a] = line_numbers[b];
                  line_numbers[b] = swap;
               end
            end
         end
         if (line_count == 0) begin
            res.value      = '0;
            res.last       = 1'b1;
            res.none_found = 1'b1;
            res.overflow   = line_overflow;
            sorted_numbers_q.push_back(res);
         end else begin
            for (int k = 0; k < line_count; k++) begin
               res.value      = line_numbers[k][VALUE_BITS-1:0];
               res.last       = (k == line_count - 1);
               res.none_found = 1'b0;
               res.overflow   = line_overflow;
               sorted_numbers_q.push_back(res);
            end
         end
         line_count    = 0;
         line_overflow = 1'b0;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         digit = 64'(ch - CHAR_ZERO);
         if (run_value > (VALUE_MAX - digit) / 64'd10) begin
            run_value     = VALUE_MAX;
            line_overflow = 1'b1;
         end else begin
            run_value = run_value * 64'd10 + digit;
         end
         run_open = 1'b1;
      end else begin
         close_run();
      end
   endtask

   always @(posedge clock) begin
      number_result_type want;
      if (reset) begin
         sorted_numbers_q.delete();
         line_count    = 0;
         run_value     = '0;
         run_open      = 1'b0;
         line_overflow = 1'b0;
      end else begin
         if (start && !busy) begin
            take_character(req_character, req_end_of_line);
         end
         if (rsp_valid) begin
            if (sorted_numbers_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer, value %0d", rsp_value));
            end else begin
               want = sorted_numbers_q.pop_front();
               if (rsp_value !== want.value) begin
                  report_mismatch($sformatf("value expected %0d, got %0d",
                                            want.value, rsp_value));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last expected %b, got %b",
                                            want.last, rsp_last));
               end
               if (rsp_none_found !== want.none_found) begin
                  report_mismatch($sformatf("none_found expected %b, got %b",
                                            want.none_found, rsp_none_found));
               end
               if (rsp_overflow !== want.overflow) begin
                  report_mismatch($sformatf("overflow expected %b, got %b",
                                            want.overflow, rsp_overflow));
               end
               compared++;
            end
         end
      end
      fail_count     <= errors;
      pending_count  <= sorted_numbers_q.size();
      compared_count <= compared;
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the digit_run_extract_and_sort testbench: clock, reset, line stimulus,
// watchdog and verdict. Depends on drs_pkg, the block and drs_checker.
module tb_top;

   import drs_pkg::*;

   localparam int MAX_NUMBERS    = 64;
   localparam int VALUE_BITS     = 31;
   localparam int ITEM_TARGET    = 500;
   localparam int QUIET_FROM     = 420;
   localparam int WATCHDOG_LIMIT = 20000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [7:0]            req_character;
   logic                  req_end_of_line;
   logic                  rsp_valid;
   logic [VALUE_BITS-1:0] rsp_value;
   logic                  rsp_last;
   logic                  rsp_none_found;
   logic                  rsp_overflow;

   int fail_count;
   int pending_count;
   int compared_count;
   int item_count   = 0;
   int line_total   = 0;
   int stall_cycles = 0;
   bit quiet        = 1'b0;

   digit_run_extract_and_sort #(
      .MAX_NUMBERS(MAX_NUMBERS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_character  (req_character),
      .req_end_of_line(req_end_of_line),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last),
      .rsp_none_found (rsp_none_found),
      .rsp_overflow   (rsp_overflow)
   );

   drs_checker #(
      .MAX_NUMBERS(MAX_NUMBERS),
      .VALUE_BITS (VALUE_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_character  (req_character),
      .req_end_of_line(req_end_of_line),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last),
      .rsp_none_found (rsp_none_found),
      .rsp_overflow   (rsp_overflow),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .compared_count (compared_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic eol);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      start           <= 1'b1;
      req_character   <= ch;
      req_end_of_line <= eol;
      do @(posedge clock); while (busy !== 1'b0);
      item_count++;
      if (eol || ch == CHAR_NEWLINE) begin
         line_total++;
      end
   endtask

   task automatic send_number(input logic [63:0] v);
      string digits;
      digits = $sformatf("%0d", v);
      if ($urandom_range(0, 7) == 0) begin
         send_item(CHAR_ZERO, 1'b0);
      end
      for (int i = 0; i < digits.len(); i++) begin
         send_item(digits[i], 1'b0);
      end
   endtask

   function automatic logic [7:0] pick_separator();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_NEWLINE);
      return c;
   endfunction

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 64'($urandom_range(0, 99));
         4, 5:       return 64'($urandom & 32'h7FFF_FFFF);
         6:          return 64'd2147483640 + 64'($urandom_range(0, 15));
         7:          return {$urandom, $urandom};
         default:    return 64'($urandom_range(0, 9));
      endcase
   endfunction

   task automatic send_line(input int n_numbers, input bit single_digits);
      logic [63:0] v;
      repeat ($urandom_range(0, 2)) send_item(pick_separator(), 1'b0);
      for (int k = 0; k < n_numbers; k++) begin
         v = single_digits ? 64'($urandom_range(0, 9)) : pick_value();
         send_number(v);
         if (k < n_numbers - 1 || $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 2)) send_item(pick_separator(), 1'b0);
         end
      end
      if ($urandom_range(0, 2) == 0) begin
         send_item(CHAR_NEWLINE, 1'b0);
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic send_noise();
      logic [7:0] c;
      repeat ($urandom_range(1, 20)) begin
         c = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 2) == 0) begin
            c = CHAR_ZERO + 8'($urandom_range(0, 9));
         end
         send_item(c, $urandom_range(0, 19) == 0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int line_no;
      reset           = 1'b1;
      start           = 1'b0;
      req_character   = '0;
      req_end_of_line = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty line whose end-of-line transfer carries a character to be ignored.
      send_item(8'hFF, 1'b1);
      // Boundary characters around the digit range, closed by a newline byte.
      send_item(8'h00, 1'b0);
      send_item(CHAR_ZERO, 1'b0);
      send_item(CHAR_ZERO - 8'd1, 1'b0);
      send_item(CHAR_NINE, 1'b0);
      send_item(CHAR_NINE + 8'd1, 1'b0);
      send_item(CHAR_NEWLINE, 1'b0);
      // One saturating number and the largest value that fits, the last run left open.
      send_number(64'd2147483648);
      send_item(8'hFF, 1'b0);
      send_number(64'd2147483647);
      send_item(CHAR_NINE, 1'b1);

      line_no = 0;
      while (item_count < ITEM_TARGET) begin
         quiet = (item_count >= QUIET_FROM);
         if (line_no == 1) begin
            send_line(MAX_NUMBERS, 1'b1);
         end else if (line_no == 3) begin
            send_line(MAX_NUMBERS + 3, 1'b1);
         end else if ($urandom_range(0, 7) == 0) begin
            send_noise();
         end else begin
            send_line($urandom_range(0, 6), 1'b0);
         end
         if (line_no % 5 == 4) begin
            wait_for_results();
         end
         line_no++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d characters in %0d lines, among them a full and an overfull store.",
               item_count, line_total);
      $display("Compared %0d sorted results, with saturating and empty lines included.",
               compared_count);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
